FILE: hw/rtl/glcpt_pkg.sv
// package: types, command codes and sizing constants for the pending command table
`timescale 1ns / 1ps
`default_nettype none
package glcpt_pkg;

   localparam int GROUP_COUNT_DEF = 16;
   localparam int MARK_W          = 8;
   localparam int ARG_W           = 8;

   localparam logic [3:0] MODE_MAX     = 4'd0;
   localparam logic [3:0] MODE_OFF     = 4'd1;
   localparam logic [3:0] MODE_LEVEL   = 4'd2;
   localparam logic [3:0] MODE_STEP    = 4'd3;
   localparam logic [3:0] MODE_UP      = 4'd4;
   localparam logic [3:0] MODE_DOWN    = 4'd5;
   localparam logic [3:0] MODE_SCENE   = 4'd6;
   localparam logic [3:0] MODE_QUERY   = 4'd7;
   localparam logic [3:0] MODE_SERVICE = 4'd8;

   localparam logic [2:0] CMD_MAX   = 3'd0;
   localparam logic [2:0] CMD_OFF   = 3'd1;
   localparam logic [2:0] CMD_LEVEL = 3'd2;
   localparam logic [2:0] CMD_STEP  = 3'd3;
   localparam logic [2:0] CMD_UP    = 3'd4;
   localparam logic [2:0] CMD_DOWN  = 3'd5;
   localparam logic [2:0] CMD_SCENE = 3'd6;
   localparam logic [2:0] CMD_QUERY = 3'd7;

   typedef struct packed {
      logic [3:0] mode;
      logic [3:0] group;
      logic [7:0] level;
      logic       from_regulator;
      logic [7:0] scene;
      logic [7:0] sensor_address;
      logic       accepted;
   } req_type;

   typedef struct packed {
      logic [2:0] command;
      logic [3:0] target_group;
      logic [7:0] argument;
      logic       cleared;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctl_cmd_type;

   typedef struct packed {
      logic hit;
   } ctl_sts_type;

   function automatic logic [MARK_W-1:0] mark_bit(input logic [2:0] cmd);
      mark_bit = MARK_W'(1) << cmd;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/group_lighting_command_pending_table.sv
// top level: per-group pending lighting command table
// timing: a request accepted at one edge is executed in the next cycle; a service
// result strobes on rsp_valid during that cycle
// sequencing: a new request is taken only when idle, after the previous one has executed
// reset: synchronous, clears all pending marks; argument stores are not cleared
// the receiver cannot stall: each result beat is valid for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none
module group_lighting_command_pending_table #(
   parameter int GROUP_COUNT = glcpt_pkg::GROUP_COUNT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire glcpt_pkg::req_type req,
   output logic                    rsp_valid,
   output glcpt_pkg::rsp_type      rsp
);

   glcpt_pkg::ctl_cmd_type cmd;
   glcpt_pkg::ctl_sts_type sts;

   glcpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   glcpt_dp #(
      .GROUP_COUNT (GROUP_COUNT)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp)
   );

endmodule
`default_nettype wire

FILE: hw/rtl/glcpt_ctrl.sv
// controller: accept and execute sequencing for the pending command table
`timescale 1ns / 1ps
`default_nettype none
module glcpt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   output logic                       rsp_valid,
   output glcpt_pkg::ctl_cmd_type     cmd,
   input  wire glcpt_pkg::ctl_sts_type sts
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign cmd.load  = start && (state_ff == ST_IDLE);
   assign cmd.exec  = (state_ff == ST_EXEC);
   assign rsp_valid = cmd.exec && sts.hit;

   a_accept_exec : assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.exec) else $error("accepted beat not executed");
   a_exec_once : assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> !busy) else $error("execute lasted more than one cycle");
   a_rsp_in_exec : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result strobe outside execute");

endmodule
`default_nettype wire

FILE: hw/rtl/glcpt_dp.sv
// datapath: per-group pending marks, argument stores and priority select
`timescale 1ns / 1ps
`default_nettype none
module glcpt_dp #(
   parameter int GROUP_COUNT = glcpt_pkg::GROUP_COUNT_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire glcpt_pkg::req_type     req,
   input  wire glcpt_pkg::ctl_cmd_type cmd,
   output glcpt_pkg::ctl_sts_type      sts,
   output glcpt_pkg::rsp_type          rsp
);

   localparam int IDX_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam logic [glcpt_pkg::MARK_W-1:0] STRONG =
      glcpt_pkg::mark_bit(glcpt_pkg::CMD_MAX) | glcpt_pkg::mark_bit(glcpt_pkg::CMD_OFF) |
      glcpt_pkg::mark_bit(glcpt_pkg::CMD_UP)  | glcpt_pkg::mark_bit(glcpt_pkg::CMD_DOWN);
   localparam logic [glcpt_pkg::MARK_W-1:0] OVERRIDE =
      STRONG | glcpt_pkg::mark_bit(glcpt_pkg::CMD_LEVEL) |
      glcpt_pkg::mark_bit(glcpt_pkg::CMD_SCENE);

   glcpt_pkg::req_type req_ff;
   logic [glcpt_pkg::MARK_W-1:0] marks_ff [GROUP_COUNT];
   logic [glcpt_pkg::ARG_W-1:0]  level_mem [GROUP_COUNT];
   logic [glcpt_pkg::ARG_W-1:0]  scene_mem [GROUP_COUNT];
   logic [glcpt_pkg::ARG_W-1:0]  query_mem [GROUP_COUNT];
   logic [glcpt_pkg::ARG_W-1:0]  level_rd_ff;
   logic [glcpt_pkg::ARG_W-1:0]  scene_rd_ff;
   logic [glcpt_pkg::ARG_W-1:0]  query_rd_ff;

   logic [IDX_W-1:0]             rd_idx;
   logic [IDX_W-1:0]             idx;
   logic                         in_range;
   logic [glcpt_pkg::MARK_W-1:0] m_cur;
   logic [glcpt_pkg::MARK_W-1:0] m_in;
   logic                         m_we;
   logic                         level_we;
   logic                         scene_we;
   logic                         query_we;
   logic [2:0]                   sel;
   logic                         any;
   logic [glcpt_pkg::ARG_W-1:0]  arg;

   assign rd_idx   = IDX_W'(req.group);
   assign idx      = IDX_W'(req_ff.group);
   assign in_range = (int'(req_ff.group) < GROUP_COUNT);
   assign m_cur    = in_range ? marks_ff[idx] : '0;

   always_comb begin
      sel = glcpt_pkg::CMD_QUERY;
      for (int i = glcpt_pkg::MARK_W - 1; i >= 0; i--) begin
         if (m_cur[i]) sel = 3'(i);
      end
   end
   assign any = (m_cur != '0);

   always_comb begin
      m_in     = m_cur;
      m_we     = 1'b1;
      level_we = 1'b0;
      scene_we = 1'b0;
      query_we = 1'b0;
      case (req_ff.mode)
         glcpt_pkg::MODE_MAX: begin
            m_in = (m_cur & ~OVERRIDE) | glcpt_pkg::mark_bit(glcpt_pkg::CMD_MAX);
         end
         glcpt_pkg::MODE_OFF: begin
            m_in = (m_cur & ~OVERRIDE) | glcpt_pkg::mark_bit(glcpt_pkg::CMD_OFF);
         end
         glcpt_pkg::MODE_LEVEL: begin
            if (req_ff.from_regulator) begin
               if ((m_cur & STRONG) == '0) begin
                  m_in     = m_cur | glcpt_pkg::mark_bit(glcpt_pkg::CMD_LEVEL);
                  level_we = 1'b1;
               end
            end else begin
               m_in = (m_cur & ~(STRONG | glcpt_pkg::mark_bit(glcpt_pkg::CMD_SCENE))) |
                      glcpt_pkg::mark_bit(glcpt_pkg::CMD_LEVEL);
               level_we = 1'b1;
            end
         end
         glcpt_pkg::MODE_STEP: begin
            m_in = m_cur | glcpt_pkg::mark_bit(glcpt_pkg::CMD_STEP);
         end
         glcpt_pkg::MODE_UP: begin
            m_in = (m_cur & ~glcpt_pkg::mark_bit(glcpt_pkg::CMD_DOWN)) |
                   glcpt_pkg::mark_bit(glcpt_pkg::CMD_UP);
         end
         glcpt_pkg::MODE_DOWN: begin
            m_in = (m_cur & ~glcpt_pkg::mark_bit(glcpt_pkg::CMD_UP)) |
                   glcpt_pkg::mark_bit(glcpt_pkg::CMD_DOWN);
         end
         glcpt_pkg::MODE_SCENE: begin
            m_in     = m_cur | glcpt_pkg::mark_bit(glcpt_pkg::CMD_SCENE);
            scene_we = 1'b1;
         end
         glcpt_pkg::MODE_QUERY: begin
            m_in     = m_cur | glcpt_pkg::mark_bit(glcpt_pkg::CMD_QUERY);
            query_we = 1'b1;
         end
         glcpt_pkg::MODE_SERVICE: begin
            if (req_ff.accepted) m_in = m_cur & ~glcpt_pkg::mark_bit(sel);
         end
         default: begin
            m_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (sel)
         glcpt_pkg::CMD_LEVEL: arg = level_rd_ff;
         glcpt_pkg::CMD_SCENE: arg = scene_rd_ff;
         glcpt_pkg::CMD_QUERY: arg = query_rd_ff;
         default:              arg = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req;
         level_rd_ff <= level_mem[rd_idx];
         scene_rd_ff <= scene_mem[rd_idx];
         query_rd_ff <= query_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && in_range) begin
         if (level_we) level_mem[idx] <= req_ff.level;
         if (scene_we) scene_mem[idx] <= req_ff.scene;
         if (query_we) query_mem[idx] <= req_ff.sensor_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GROUP_COUNT; i++) marks_ff[i] <= '0;
      end else if (cmd.exec && in_range && m_we) begin
         marks_ff[idx] <= m_in;
      end
   end

   assign sts.hit          = in_range && any && (req_ff.mode == glcpt_pkg::MODE_SERVICE);
   assign rsp.command      = sel;
   assign rsp.target_group = req_ff.group;
   assign rsp.argument     = arg;
   assign rsp.cleared      = req_ff.accepted;

   a_max_marks : assert property (@(posedge clock) disable iff (reset)
      cmd.exec && in_range && (req_ff.mode == glcpt_pkg::MODE_MAX)
      |=> marks_ff[$past(idx)][glcpt_pkg::CMD_MAX])
      else $error("recall max not marked");
   a_clear_on_accept : assert property (@(posedge clock) disable iff (reset)
      cmd.exec && sts.hit && req_ff.accepted
      |=> !marks_ff[$past(idx)][$past(sel)])
      else $error("accepted command still pending");

endmodule
`default_nettype wire

FILE: sim/tb_group_lighting_command_pending_table.sv
// testbench: pending command table checked beat by beat against directed rows and a predictor
`timescale 1ns / 1ps
module tb_group_lighting_command_pending_table;
   import glcpt_pkg::*;

   localparam int GROUPS      = GROUP_COUNT_DEF;
   localparam int RANDOM_BEATS = 483;
   localparam int STALL_LIMIT = 1000;
   localparam int TAIL_CYCLES = 8;

   localparam logic [3:0] MODE_UNUSED_LO = 4'd9;
   localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

   localparam logic [7:0] MAX_BIT   = 8'd1 << CMD_MAX;
   localparam logic [7:0] OFF_BIT   = 8'd1 << CMD_OFF;
   localparam logic [7:0] LEVEL_BIT = 8'd1 << CMD_LEVEL;
   localparam logic [7:0] STEP_BIT  = 8'd1 << CMD_STEP;
   localparam logic [7:0] UP_BIT    = 8'd1 << CMD_UP;
   localparam logic [7:0] DOWN_BIT  = 8'd1 << CMD_DOWN;
   localparam logic [7:0] SCENE_BIT = 8'd1 << CMD_SCENE;
   localparam logic [7:0] QUERY_BIT = 8'd1 << CMD_QUERY;
   localparam logic [7:0] STRONG    = MAX_BIT | OFF_BIT | UP_BIT | DOWN_BIT;

   typedef struct {
      req_type r;
      bit      typed;
      bit      has;
      rsp_type want;
   } dir_row_t;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_valid;
   rsp_type rsp;

   logic    beat_typed;
   logic    beat_has;
   rsp_type beat_rsp;
   logic    taken;

   logic [7:0] marks [GROUPS];
   logic [7:0] level_arg [GROUPS];
   logic [7:0] scene_arg [GROUPS];
   logic [7:0] query_arg [GROUPS];

   rsp_type expected_offers [$];
   int      errors;
   int      quiet_cycles;
   dir_row_t dir_rows [];

   group_lighting_command_pending_table dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit apply_request(input req_type r, output rsp_type offer);
      logic [7:0] m;
      bit         found;
      offer = '0;
      found = 1'b0;
      if (int'(r.group) >= GROUPS) return 1'b0;
      m = marks[r.group];
      case (r.mode)
         MODE_MAX: m = (m & ~(STRONG | LEVEL_BIT | SCENE_BIT)) | MAX_BIT;
         MODE_OFF: m = (m & ~(STRONG | LEVEL_BIT | SCENE_BIT)) | OFF_BIT;
         MODE_LEVEL: begin
            if (!r.from_regulator) begin
               m = (m & ~(STRONG | SCENE_BIT)) | LEVEL_BIT;
               level_arg[r.group] = r.level;
            end else if ((m & STRONG) == 8'd0) begin
               m = m | LEVEL_BIT;
               level_arg[r.group] = r.level;
            end
         end
         MODE_STEP: m = m | STEP_BIT;
         MODE_UP: m = (m & ~DOWN_BIT) | UP_BIT;
         MODE_DOWN: m = (m & ~UP_BIT) | DOWN_BIT;
         MODE_SCENE: begin
            m = m | SCENE_BIT;
            scene_arg[r.group] = r.scene;
         end
         MODE_QUERY: begin
            m = m | QUERY_BIT;
            query_arg[r.group] = r.sensor_address;
         end
         MODE_SERVICE: begin
            for (int c = 0; c < 8; c++) begin
               if (m[c] && !found) begin
                  found = 1'b1;
                  offer.command = 3'(c);
               end
            end
            if (!found) return 1'b0;
            offer.target_group = r.group;
            case (offer.command)
               CMD_LEVEL: offer.argument = level_arg[r.group];
               CMD_SCENE: offer.argument = scene_arg[r.group];
               CMD_QUERY: offer.argument = query_arg[r.group];
               default: offer.argument = '0;
            endcase
            offer.cleared = r.accepted;
            if (r.accepted) m[offer.command] = 1'b0;
            marks[r.group] = m;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
      marks[r.group] = m;
      return 1'b0;
   endfunction

   function automatic dir_row_t step_row(input logic [3:0] mode, input logic [3:0] group,
                                         input logic [7:0] level, input bit regul,
                                         input logic [7:0] scene, input logic [7:0] addr,
                                         input bit acc, input bit typed, input bit has,
                                         input logic [2:0] cmd, input logic [7:0] arg);
      dir_row_t d;
      d.r = '{mode: mode, group: group, level: level, from_regulator: regul, scene: scene,
              sensor_address: addr, accepted: acc};
      d.typed = typed;
      d.has = has;
      d.want = '{command: cmd, target_group: group, argument: arg, cleared: acc};
      return d;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 38) r.mode = MODE_SERVICE;
      else if (pick < 95) r.mode = 4'($urandom_range(7));
      else r.mode = 4'($urandom_range(15, 9));
      r.group = ($urandom_range(99) < 70) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
      r.level = 8'($urandom);
      r.from_regulator = 1'($urandom_range(1));
      r.scene = 8'($urandom);
      r.sensor_address = 8'($urandom);
      r.accepted = ($urandom_range(99) < 75);
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_beat(input req_type r, input bit typed, input bit has,
                            input rsp_type want, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req <= random_request();
         @(negedge clock);
      end
      start <= 1'b1;
      req <= r;
      beat_typed <= typed;
      beat_has <= has;
      beat_rsp <= want;
      @(negedge clock);
      while (!taken) @(negedge clock);
   endtask

   task automatic drain_offers();
      start <= 1'b0;
      @(negedge clock);
      while (expected_offers.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      taken <= !reset && start && !busy;
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      bit      hit;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_offers.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got %p", $time, rsp);
               errors++;
            end else begin
               want = expected_offers.pop_front();
               if (rsp.command !== want.command) begin
                  $display("%0t: command expected %0d got %0d", $time, want.command,
                           rsp.command);
                  errors++;
               end
               if (rsp.target_group !== want.target_group) begin
                  $display("%0t: target_group expected %0d got %0d", $time,
                           want.target_group, rsp.target_group);
                  errors++;
               end
               if (rsp.argument !== want.argument) begin
                  $display("%0t: argument expected %0d got %0d", $time, want.argument,
                           rsp.argument);
                  errors++;
               end
               if (rsp.cleared !== want.cleared) begin
                  $display("%0t: cleared expected %0d got %0d", $time, want.cleared,
                           rsp.cleared);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            hit = apply_request(req, got);
            if (beat_typed) begin
               if (beat_has) expected_offers.push_back(beat_rsp);
            end else if (hit) begin
               expected_offers.push_back(got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase_idle [3];
      reset = 1'b1;
      start = 1'b0;
      req = '0;
      beat_typed = 1'b0;
      beat_has = 1'b0;
      beat_rsp = '0;
      taken = 1'b0;
      errors = 0;
      quiet_cycles = 0;
      for (int g = 0; g < GROUPS; g++) marks[g] = '0;
      phase_idle = '{14, 47, 0};

      dir_rows = '{
         step_row(MODE_SERVICE, 4'd0, 8'd0, 0, 8'd0, 8'd0, 1, 1, 0, CMD_MAX, 8'd0),
         step_row(MODE_MAX, 4'd0, 8'd0, 0, 8'd0, 8'd0, 0, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_SERVICE, 4'd0, 8'd0, 0, 8'd0, 8'd0, 1, 1, 1, CMD_MAX, 8'd0),
         step_row(MODE_SERVICE, 4'd0, 8'd0, 0, 8'd0, 8'd0, 1, 1, 0, CMD_MAX, 8'd0),
         step_row(MODE_OFF, 4'd15, 8'd0, 0, 8'd0, 8'd0, 0, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_LEVEL, 4'd15, 8'd255, 0, 8'd0, 8'd0, 0, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_SERVICE, 4'd15, 8'd0, 0, 8'd0, 8'd0, 0, 1, 1, CMD_LEVEL, 8'd255),
         step_row(MODE_SERVICE, 4'd15, 8'd0, 0, 8'd0, 8'd0, 1, 1, 1, CMD_LEVEL, 8'd255),
         step_row(MODE_UP, 4'd5, 8'd0, 0, 8'd0, 8'd0, 0, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_LEVEL, 4'd5, 8'hAA, 1, 8'd0, 8'd0, 0, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_DOWN, 4'd5, 8'd0, 0, 8'd0, 8'd0, 0, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_STEP, 4'd5, 8'd0, 0, 8'd0, 8'd0, 0, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_STEP, 4'd5, 8'd0, 0, 8'd0, 8'd0, 0, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_SCENE, 4'd5, 8'd0, 0, 8'd255, 8'd0, 0, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_QUERY, 4'd5, 8'd0, 0, 8'd0, 8'd255, 0, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_SERVICE, 4'd5, 8'd0, 0, 8'd0, 8'd0, 1, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_SERVICE, 4'd5, 8'd0, 0, 8'd0, 8'd0, 1, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_SERVICE, 4'd5, 8'd0, 0, 8'd0, 8'd0, 1, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_SERVICE, 4'd5, 8'd0, 0, 8'd0, 8'd0, 1, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_LEVEL, 4'd7, 8'd0, 1, 8'd0, 8'd0, 0, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_SCENE, 4'd7, 8'd0, 0, 8'd0, 8'd0, 0, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_QUERY, 4'd7, 8'd0, 0, 8'd0, 8'd0, 0, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_MAX, 4'd7, 8'd0, 0, 8'd0, 8'd0, 0, 0, 0, CMD_MAX, 8'd0),
         step_row(MODE_SERVICE, 4'd7, 8'd0, 0, 8'd0, 8'd0, 1, 1, 1, CMD_MAX, 8'd0),
         step_row(MODE_UNUSED_LO, 4'd7, 8'd255, 1, 8'd255, 8'd255, 1, 1, 0, CMD_MAX, 8'd0),
         step_row(MODE_UNUSED_HI, 4'd15, 8'd255, 1, 8'd255, 8'd255, 1, 1, 0, CMD_MAX, 8'd0),
         step_row(MODE_SERVICE, 4'd7, 8'd0, 0, 8'd0, 8'd0, 1, 1, 1, CMD_QUERY, 8'd0),
         step_row(MODE_SERVICE, 4'd7, 8'd0, 0, 8'd0, 8'd0, 1, 1, 0, CMD_MAX, 8'd0)
      };

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         send_beat(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].has, dir_rows[i].want, 14);
      end
      drain_offers();

      // sender idles 14 percent, then 47 percent, then never
      for (int p = 0; p < 3; p++) begin
         for (int n = 0; n < RANDOM_BEATS; n++) begin
            send_beat(random_request(), 1'b0, 1'b0, '0, phase_idle[p]);
         end
         drain_offers();
      end

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
